// File: hdl/wfdr_pkg.sv
package wfdr_pkg;

   // Operation codes carried in the func field of an input word.
   typedef enum logic [2:0] {
      FUNC_PUSH    = 3'd0,
      FUNC_POP     = 3'd1,
      FUNC_ADVANCE = 3'd2,
      FUNC_QUERY   = 3'd3,
      FUNC_PEER    = 3'd4,
      FUNC_DEPOSIT = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FAIL = 2'd1,
      STATUS_ZERO = 2'd2
   } status_type;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 9;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RING_KIND = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RING_SIZE = 4'd1;

   // Fixed field widths of the channels.
   localparam int PTR_BITS   = 8;
   localparam int COUNT_BITS = 9;
   localparam int WORD_BITS  = 64;
   localparam int ALU_BITS   = 11;

   typedef struct packed {
      logic neg;
      logic ge_size;
      logic gt_size;
   } alu_flags_type;

endpackage

// File: hdl/wrap_flag_descriptor_ring_core.sv
// Descriptor ring with wrap-bit pointers.
// Input words arrive on the req_ channel (valid/ready), results leave on the
// rsp_ channel (valid/ready), and ring_kind / ring_size are written through
// the csr_ channel, which is always ready and must only be used while idle.
// Each input word gives one result word, except a successful pop of n
// entries, which gives n words with rsp_last set on the final one.
// One word is handled at a time through a small sequencer around a single
// shared adder/comparator. Load peer, deposit, query, rejected operations and
// a zero count go straight from execution to the result; push and advance
// first make one or two passes of the adder for the pointer wrap; a pop of n
// entries advances the pointer the same way, then reads each entry from memory
// and presents it as a word. req_ready rises in the cycle the last result word
// turns valid, so a new word is accepted only after the last one is finished.
// After reset the entry memory is cleared one entry per cycle while req_ready
// stays low. A stalled receiver holds the result in the output register and
// the sequencer waits before loading the next one.
module wrap_flag_descriptor_ring_core #(
   parameter int RING_DEPTH = 256,
   parameter int MAX_BURST  = 64,
   parameter int ENTRY_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_func,
   input  logic [wfdr_pkg::WORD_BITS-1:0]      req_entry_value,
   input  logic [wfdr_pkg::COUNT_BITS-1:0]     req_burst_count,
   input  logic [wfdr_pkg::PTR_BITS-1:0]       req_peer_index,
   input  logic                                req_peer_wrap,
   input  logic [wfdr_pkg::PTR_BITS-1:0]       req_deposit_slot,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [wfdr_pkg::WORD_BITS-1:0]      rsp_entry_data,
   output logic [wfdr_pkg::COUNT_BITS-1:0]     rsp_slot_count,
   output logic                                rsp_last,
   output logic [wfdr_pkg::PTR_BITS-1:0]       rsp_own_index,
   output logic                                rsp_own_wrap,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wfdr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wfdr_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import wfdr_pkg::*;

   localparam int AW        = $clog2(RING_DEPTH);
   localparam int LW        = $clog2(MAX_BURST + 1);
   localparam int SIZE_LIM  = (RING_DEPTH < 256) ? RING_DEPTH : 256;
   localparam int PTR_SLOTS = 1 << PTR_BITS;

   typedef enum logic [7:0] {
      S_CLEAR   = 8'b0000_0001,
      S_IDLE    = 8'b0000_0010,
      S_EXEC    = 8'b0000_0100,
      S_ADV1    = 8'b0000_1000,
      S_ADV2    = 8'b0001_0000,
      S_POP_RD  = 8'b0010_0000,
      S_POP_OUT = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   // Pointer index to memory slot, index modulo RING_DEPTH, built at
   // elaboration as a constant table.
   function automatic logic [PTR_SLOTS*AW-1:0] slot_tab_build();
      logic [PTR_SLOTS*AW-1:0] t;
      t = '0;
      for (int i = 0; i < PTR_SLOTS; i++) begin
         t[i*AW +: AW] = AW'(i % RING_DEPTH);
      end
      return t;
   endfunction

   localparam logic [PTR_SLOTS*AW-1:0] SLOT_TAB = slot_tab_build();

   function automatic logic [AW-1:0] slot_of(input logic [PTR_BITS-1:0] idx);
      return SLOT_TAB[idx*AW +: AW];
   endfunction

   logic [ENTRY_BITS-1:0] mem [RING_DEPTH];

   state_type               state_ff, state_in;
   func_type                func_ff, func_in;
   logic [ENTRY_BITS-1:0]   val_ff, val_in;
   logic [COUNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [PTR_BITS-1:0]     pidx_ff, pidx_in;
   logic                    pwrap_ff, pwrap_in;
   logic [PTR_BITS-1:0]     dslot_ff, dslot_in;
   logic [PTR_BITS-1:0]     own_idx_ff, own_idx_in;
   logic                    own_wrap_ff, own_wrap_in;
   logic [PTR_BITS-1:0]     peer_idx_ff, peer_idx_in;
   logic                    peer_wrap_ff, peer_wrap_in;
   logic                    kind_ff, kind_in;
   logic [COUNT_BITS-1:0]   size_ff, size_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [PTR_BITS-1:0]     pos_ff, pos_in;
   logic [LW-1:0]           left_ff, left_in;
   logic [COUNT_BITS-1:0]   sum_ff, sum_in;
   status_type              st_ff, st_in;
   logic [COUNT_BITS-1:0]   scount_ff, scount_in;
   logic [ENTRY_BITS-1:0]   rd_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [WORD_BITS-1:0]    rsp_data_ff, rsp_data_in;
   logic [COUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [PTR_BITS-1:0]     rsp_idx_ff, rsp_idx_in;
   logic                    rsp_wrap_ff, rsp_wrap_in;

   logic                    mem_we;
   logic [AW-1:0]           mem_wa;
   logic [ENTRY_BITS-1:0]   mem_wd;
   logic                    rd_en;

   logic [COUNT_BITS-1:0]   alu_a, alu_b, alu_c;
   logic [ALU_BITS-1:0]     alu_res;
   alu_flags_type           alu_fl;

   logic                    out_free;
   logic                    same_idx, ring_full, ring_empty, wrapped, size_form;
   logic                    own_past_size;
   state_type               adv_next;

   wfdr_alu u_alu (
      .opa   (alu_a),
      .opb   (alu_b),
      .opc   (alu_c),
      .size  (size_ff),
      .res   (alu_res),
      .flags (alu_fl)
   );

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign same_idx      = (own_idx_ff == peer_idx_ff);
   assign wrapped       = (own_wrap_ff != peer_wrap_ff);
   assign ring_full     = same_idx && wrapped;
   assign ring_empty    = same_idx && !wrapped;
   assign size_form     = (kind_ff == wrapped);
   assign own_past_size = (COUNT_BITS'(own_idx_ff) >= size_ff);
   assign adv_next      = (func_ff == FUNC_POP) ? S_POP_RD : S_DONE;

   // Configuration: the size is clamped to the usable range when written.
   always_comb begin
      kind_in = kind_ff;
      size_in = size_ff;
      if (csr_valid) begin
         if (csr_index == CSR_RING_KIND) begin
            kind_in = csr_wdata[0];
         end else if (csr_index == CSR_RING_SIZE) begin
            if (csr_wdata == '0) begin
               size_in = COUNT_BITS'(1);
            end else if (csr_wdata > COUNT_BITS'(SIZE_LIM)) begin
               size_in = COUNT_BITS'(SIZE_LIM);
            end else begin
               size_in = csr_wdata;
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      pidx_in      = pidx_ff;
      pwrap_in     = pwrap_ff;
      dslot_in     = dslot_ff;
      own_idx_in   = own_idx_ff;
      own_wrap_in  = own_wrap_ff;
      peer_idx_in  = peer_idx_ff;
      peer_wrap_in = peer_wrap_ff;
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      sum_in       = sum_ff;
      st_in        = st_ff;
      scount_in    = scount_ff;
      mem_we       = 1'b0;
      mem_wa       = slot_of(own_idx_ff);
      mem_wd       = '0;
      rd_en        = 1'b0;
      alu_a        = COUNT_BITS'(own_idx_ff);
      alu_b        = cnt_ff;
      alu_c        = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_wrap_in   = rsp_wrap_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(RING_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in  = func_type'(req_func);
               val_in   = req_entry_value[ENTRY_BITS-1:0];
               cnt_in   = req_burst_count;
               pidx_in  = req_peer_index;
               pwrap_in = req_peer_wrap;
               dslot_in = req_deposit_slot;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            st_in     = STATUS_OK;
            scount_in = '0;
            state_in  = S_DONE;
            case (func_ff)
               FUNC_PUSH: begin
                  if (val_ff == '0) begin
                     st_in = STATUS_ZERO;
                  end else if (kind_ff || ring_full) begin
                     st_in = STATUS_FAIL;
                  end else begin
                     mem_we   = 1'b1;
                     mem_wd   = val_ff;
                     cnt_in   = COUNT_BITS'(1);
                     state_in = S_ADV1;
                  end
               end
               FUNC_POP: begin
                  if (!kind_ff || ring_empty || cnt_ff > COUNT_BITS'(MAX_BURST)
                      || cnt_ff > size_ff) begin
                     st_in = STATUS_FAIL;
                  end else if (cnt_ff != '0) begin
                     pos_in   = own_idx_ff;
                     left_in  = LW'(cnt_ff);
                     state_in = S_ADV1;
                  end
               end
               FUNC_ADVANCE: begin
                  if (kind_ff || ring_full || cnt_ff > size_ff) begin
                     st_in = STATUS_FAIL;
                  end else if (cnt_ff != '0) begin
                     state_in = S_ADV1;
                  end
               end
               FUNC_QUERY: begin
                  alu_c = COUNT_BITS'(own_idx_ff);
                  if (size_form) begin
                     alu_a = size_ff;
                     alu_b = COUNT_BITS'(peer_idx_ff);
                  end else begin
                     alu_a = COUNT_BITS'(peer_idx_ff);
                     alu_b = '0;
                  end
                  if ((!kind_ff && ring_full) || (kind_ff && ring_empty)) begin
                     scount_in = '0;
                  end else if (alu_fl.neg || alu_fl.gt_size) begin
                     st_in = STATUS_FAIL;
                  end else begin
                     scount_in = alu_res[COUNT_BITS-1:0];
                  end
               end
               FUNC_PEER: begin
                  peer_idx_in  = pidx_ff;
                  peer_wrap_in = pwrap_ff;
               end
               FUNC_DEPOSIT: begin
                  mem_we = 1'b1;
                  mem_wa = slot_of(dslot_ff);
                  mem_wd = val_ff;
               end
               default: begin
                  st_in = STATUS_FAIL;
               end
            endcase
         end
         S_ADV1: begin
            // First pass: own + n, unless the index already sits past the size.
            if (own_past_size) begin
               own_wrap_in = !own_wrap_ff;
               own_idx_in  = PTR_BITS'(cnt_ff - COUNT_BITS'(1));
               state_in    = adv_next;
            end else if (alu_fl.ge_size) begin
               sum_in   = alu_res[COUNT_BITS-1:0];
               state_in = S_ADV2;
            end else begin
               own_idx_in = alu_res[PTR_BITS-1:0];
               state_in   = adv_next;
            end
         end
         S_ADV2: begin
            alu_a       = sum_ff;
            alu_b       = '0;
            alu_c       = size_ff;
            own_idx_in  = alu_res[PTR_BITS-1:0];
            own_wrap_in = !own_wrap_ff;
            state_in    = adv_next;
         end
         S_POP_RD: begin
            // Read the slot and zero it in the same cycle; the read sees the old word.
            rd_en   = 1'b1;
            mem_we  = 1'b1;
            mem_wa  = slot_of(pos_ff);
            alu_a   = COUNT_BITS'(pos_ff);
            alu_b   = COUNT_BITS'(1);
            pos_in  = alu_fl.ge_size ? '0 : alu_res[PTR_BITS-1:0];
            left_in = left_ff - LW'(1);
            state_in = S_POP_OUT;
         end
         S_POP_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_data_in   = WORD_BITS'(rd_ff);
               rsp_count_in  = '0;
               rsp_last_in   = (left_ff == '0);
               rsp_idx_in    = own_idx_ff;
               rsp_wrap_in   = own_wrap_ff;
               state_in      = (left_ff == '0) ? S_IDLE : S_POP_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_data_in   = '0;
               rsp_count_in  = scount_ff;
               rsp_last_in   = 1'b1;
               rsp_idx_in    = own_idx_ff;
               rsp_wrap_in   = own_wrap_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_ff <= mem[slot_of(pos_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         own_idx_ff   <= '0;
         own_wrap_ff  <= 1'b0;
         peer_idx_ff  <= '0;
         peer_wrap_ff <= 1'b0;
         kind_ff      <= 1'b0;
         size_ff      <= COUNT_BITS'(SIZE_LIM);
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         own_idx_ff   <= own_idx_in;
         own_wrap_ff  <= own_wrap_in;
         peer_idx_ff  <= peer_idx_in;
         peer_wrap_ff <= peer_wrap_in;
         kind_ff      <= kind_in;
         size_ff      <= size_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      val_ff        <= val_in;
      cnt_ff        <= cnt_in;
      pidx_ff       <= pidx_in;
      pwrap_ff      <= pwrap_in;
      dslot_ff      <= dslot_in;
      pos_ff        <= pos_in;
      sum_ff        <= sum_in;
      st_ff         <= st_in;
      scount_ff     <= scount_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_wrap_ff   <= rsp_wrap_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_entry_data = rsp_data_ff;
   assign rsp_slot_count = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_own_index  = rsp_idx_ff;
   assign rsp_own_wrap   = rsp_wrap_ff;

endmodule

// File: hdl/wfdr_alu.sv
module wfdr_alu (
   input  logic [wfdr_pkg::COUNT_BITS-1:0] opa,
   input  logic [wfdr_pkg::COUNT_BITS-1:0] opb,
   input  logic [wfdr_pkg::COUNT_BITS-1:0] opc,
   input  logic [wfdr_pkg::COUNT_BITS-1:0] size,
   output logic [wfdr_pkg::ALU_BITS-1:0]   res,
   output wfdr_pkg::alu_flags_type         flags
);
   import wfdr_pkg::*;

   logic [ALU_BITS-2:0] mag;

   // Shared add/subtract with a compare against the ring size. Operands are
   // nine bits, so an eleven-bit two's complement result never overflows.
   assign res = ALU_BITS'(opa) + ALU_BITS'(opb) - ALU_BITS'(opc);
   assign mag = res[ALU_BITS-2:0];

   always_comb begin
      flags.neg     = res[ALU_BITS-1];
      flags.ge_size = !res[ALU_BITS-1] && (mag >= (ALU_BITS-1)'(size));
      flags.gt_size = !res[ALU_BITS-1] && (mag > (ALU_BITS-1)'(size));
   end

endmodule

// File: sim/tb_wrap_flag_descriptor_ring_core.sv
`timescale 1ns / 100ps

module tb_wrap_flag_descriptor_ring_core;
   import wfdr_pkg::*;

   localparam int SLOTS = 256;
   localparam int BURST_MAX = 64;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 30;
   localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [2:0]            func;
      logic [WORD_BITS-1:0]  value;
      logic [COUNT_BITS-1:0] count;
      logic [PTR_BITS-1:0]   peer_idx;
      logic                  peer_wrap;
      logic [PTR_BITS-1:0]   slot;
   } ring_op_type;

   typedef struct packed {
      status_type            status;
      logic [WORD_BITS-1:0]  data;
      logic [COUNT_BITS-1:0] count;
      logic                  last;
      logic [PTR_BITS-1:0]   idx;
      logic                  wrap;
   } ring_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [2:0]                  req_func = '0;
   logic [WORD_BITS-1:0]        req_entry_value = '0;
   logic [COUNT_BITS-1:0]       req_burst_count = '0;
   logic [PTR_BITS-1:0]         req_peer_index = '0;
   logic                        req_peer_wrap = 1'b0;
   logic [PTR_BITS-1:0]         req_deposit_slot = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [1:0]                  rsp_status;
   logic [WORD_BITS-1:0]        rsp_entry_data;
   logic [COUNT_BITS-1:0]       rsp_slot_count;
   logic                        rsp_last;
   logic [PTR_BITS-1:0]         rsp_own_index;
   logic                        rsp_own_wrap;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_wdata = '0;

   // Ring state as software sees it, updated when a word is accepted.
   logic [WORD_BITS-1:0]  ring_mem [SLOTS];
   logic [PTR_BITS-1:0]   own_idx;
   logic                  own_wrap;
   logic [PTR_BITS-1:0]   peer_idx;
   logic                  peer_wrap;
   logic                  cfg_kind = 1'b0;
   logic [COUNT_BITS-1:0] cfg_size = 9'd256;

   ring_op_type   op_queue [$];
   ring_word_type owed_words [$];
   ring_op_type   offer;
   ring_op_type   next_op;
   int         queued = 0;
   int         mismatches = 0;
   int         send_gap;
   int         take_gap;
   int         stall_next;
   int         hold_left;
   logic       hold_arm = 1'b0;
   logic       hold_done;
   logic       idle_on = 1'b1;

   wrap_flag_descriptor_ring_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_entry_value (req_entry_value),
      .req_burst_count (req_burst_count),
      .req_peer_index  (req_peer_index),
      .req_peer_wrap   (req_peer_wrap),
      .req_deposit_slot(req_deposit_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_data  (rsp_entry_data),
      .rsp_slot_count  (rsp_slot_count),
      .rsp_last        (rsp_last),
      .rsp_own_index   (rsp_own_index),
      .rsp_own_wrap    (rsp_own_wrap),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int draw_gap();
      return idle_on ? $urandom_range(0, 16) : 0;
   endfunction

   function automatic int live_size();
      int s;
      s = cfg_size;
      if (s == 0) s = 1;
      if (s > SLOTS) s = SLOTS;
      return s;
   endfunction

   function automatic void owe(status_type st, logic [WORD_BITS-1:0] data,
                               logic [COUNT_BITS-1:0] cnt, logic last);
      ring_word_type w;
      w.status = st;
      w.data = data;
      w.count = cnt;
      w.last = last;
      w.idx = own_idx;
      w.wrap = own_wrap;
      owed_words.push_back(w);
   endfunction

   function automatic void step_own(int n, int span);
      int s;
      if (n == 0) return;
      // An index left beyond a shrunken ring restarts at the front of the next lap.
      if (own_idx >= span) begin
         own_wrap = ~own_wrap;
         s = n - 1;
         own_idx = s[PTR_BITS-1:0];
         return;
      end
      s = own_idx + n;
      if (s >= span) begin
         own_wrap = ~own_wrap;
         s -= span;
      end
      own_idx = s[PTR_BITS-1:0];
   endfunction

   function automatic void ring_apply(ring_op_type op);
      int span, pos, c, own, peer, k;
      logic full, empty;
      logic [WORD_BITS-1:0] taken [BURST_MAX];
      span = live_size();
      full = (own_idx == peer_idx) && (own_wrap != peer_wrap);
      empty = (own_idx == peer_idx) && (own_wrap == peer_wrap);
      case (op.func)
         FUNC_PUSH: begin
            if (op.value == '0) owe(STATUS_ZERO, '0, '0, 1'b1);
            else if (cfg_kind || full) owe(STATUS_FAIL, '0, '0, 1'b1);
            else begin
               ring_mem[own_idx] = op.value;
               step_own(1, span);
               owe(STATUS_OK, '0, '0, 1'b1);
            end
         end
         FUNC_POP: begin
            if (!cfg_kind || empty || op.count > BURST_MAX || op.count > span) begin
               owe(STATUS_FAIL, '0, '0, 1'b1);
            end else if (op.count == 0) begin
               owe(STATUS_OK, '0, '0, 1'b1);
            end else begin
               pos = own_idx;
               for (k = 0; k < op.count; k++) begin
                  taken[k] = ring_mem[pos % SLOTS];
                  ring_mem[pos % SLOTS] = '0;
                  pos = (pos + 1 >= span) ? 0 : pos + 1;
               end
               step_own(op.count, span);
               for (k = 0; k < op.count; k++)
                  owe(STATUS_OK, taken[k], '0, k + 1 == op.count);
            end
         end
         FUNC_ADVANCE: begin
            if (cfg_kind || full || op.count > span) owe(STATUS_FAIL, '0, '0, 1'b1);
            else begin
               step_own(op.count, span);
               owe(STATUS_OK, '0, '0, 1'b1);
            end
         end
         FUNC_QUERY: begin
            own = own_idx;
            peer = peer_idx;
            if ((!cfg_kind && full) || (cfg_kind && empty)) c = 0;
            else if (!cfg_kind) c = (own_wrap != peer_wrap) ? peer - own : span - own + peer;
            else c = (own_wrap != peer_wrap) ? span - own + peer : peer - own;
            if (c < 0 || c > span) owe(STATUS_FAIL, '0, '0, 1'b1);
            else owe(STATUS_OK, '0, c[COUNT_BITS-1:0], 1'b1);
         end
         FUNC_PEER: begin
            peer_idx = op.peer_idx;
            peer_wrap = op.peer_wrap;
            owe(STATUS_OK, '0, '0, 1'b1);
         end
         FUNC_DEPOSIT: begin
            ring_mem[op.slot] = op.value;
            owe(STATUS_OK, '0, '0, 1'b1);
         end
         default: owe(STATUS_FAIL, '0, '0, 1'b1);
      endcase
   endfunction

   function automatic void check_field(string name, logic [WORD_BITS-1:0] want,
                                       logic [WORD_BITS-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_word();
      ring_word_type want;
      if (owed_words.size() == 0) begin
         $error("result word with nothing pending: status %0d data %0h",
                rsp_status, rsp_entry_data);
         mismatches++;
         return;
      end
      want = owed_words.pop_front();
      check_field("status", WORD_BITS'(want.status), WORD_BITS'(rsp_status));
      check_field("entry_data", want.data, rsp_entry_data);
      check_field("slot_count", WORD_BITS'(want.count), WORD_BITS'(rsp_slot_count));
      check_field("last", WORD_BITS'(want.last), WORD_BITS'(rsp_last));
      check_field("own_index", WORD_BITS'(want.idx), WORD_BITS'(rsp_own_index));
      check_field("own_wrap", WORD_BITS'(want.wrap), WORD_BITS'(rsp_own_wrap));
   endfunction

   // Every field random, so that fields an operation ignores still toggle.
   function automatic ring_op_type any_op(logic [2:0] f);
      ring_op_type op;
      op.func = f;
      op.value = {$urandom, $urandom};
      op.count = COUNT_BITS'($urandom_range(0, 511));
      op.peer_idx = PTR_BITS'($urandom_range(0, 255));
      op.peer_wrap = 1'($urandom_range(0, 1));
      op.slot = PTR_BITS'($urandom_range(0, 255));
      return op;
   endfunction

   task automatic queue_op(ring_op_type op);
      op_queue.push_back(op);
      queued++;
   endtask

   task automatic wait_idle();
      while (op_queue.size() != 0 || req_valid) @(negedge clock);
   endtask

   task automatic drain();
      wait_idle();
      while (owed_words.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_RING_KIND) cfg_kind = data[0];
      else if (idx == CSR_RING_SIZE) cfg_size = data;
   endtask

   // Sender: the gap drawn with a word is spent after that word is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
         foreach (ring_mem[i]) ring_mem[i] = '0;
         own_idx = '0;
         own_wrap = 1'b0;
         peer_idx = '0;
         peer_wrap = 1'b0;
      end else begin
         if (req_valid && req_ready) ring_apply(offer);
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (op_queue.size() != 0) begin
               next_op = op_queue.pop_front();
               offer <= next_op;
               req_func <= next_op.func;
               req_entry_value <= next_op.value;
               req_burst_count <= next_op.count;
               req_peer_index <= next_op.peer_idx;
               req_peer_wrap <= next_op.peer_wrap;
               req_deposit_slot <= next_op.slot;
               req_valid <= 1'b1;
               send_gap <= draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result word and stalls after it for a drawn time.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_word();
            stall_next = draw_gap();
         end else begin
            stall_next = (take_gap != 0) ? take_gap - 1 : 0;
         end
         take_gap <= stall_next;
         rsp_ready <= (stall_next == 0) && (hold_left == 0);
      end
   end

   // One long receiver hold-off so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end
   end

   initial begin : stimulus
      ring_op_type op;
      int pos, span, d, k, n, left, ph, start, spins;
      logic w;
      logic [CSR_DATA_BITS-1:0] phase_size [PHASES];

      phase_size = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd2, 9'd255, 9'd64, 9'd3, 9'd200, 9'd256};
      phase_size[7] = CSR_DATA_BITS'($urandom_range(1, 511));
      phase_size[8] = CSR_DATA_BITS'($urandom_range(1, 511));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Free ring at full size, straight out of reset.
      op = any_op(FUNC_PUSH); op.value = '0; queue_op(op);
      op = any_op(FUNC_PUSH); op.value = '1; queue_op(op);
      op = any_op(FUNC_PUSH); op.value = 64'd1; queue_op(op);
      op = any_op(FUNC_QUERY); queue_op(op);
      op = any_op(FUNC_ADVANCE); op.count = 9'd0; queue_op(op);
      op = any_op(FUNC_ADVANCE); op.count = 9'd257; queue_op(op);
      op = any_op(FUNC_ADVANCE); op.count = 9'd256; queue_op(op);
      op = any_op(FUNC_POP); op.count = 9'd1; queue_op(op);
      op = any_op(FUNC_UNUSED_6); queue_op(op);
      op = any_op(FUNC_UNUSED_7); queue_op(op);
      // Peer one lap behind at the same index: the ring is full.
      op = any_op(FUNC_PEER); op.peer_idx = 8'd2; op.peer_wrap = 1'b0; queue_op(op);
      op = any_op(FUNC_PUSH); queue_op(op);
      op = any_op(FUNC_QUERY); queue_op(op);
      op = any_op(FUNC_DEPOSIT); op.slot = 8'd255; op.value = '0; queue_op(op);

      drain();
      write_csr(CSR_RING_KIND, 9'd1);
      write_csr(CSR_RING_SIZE, 9'd256);

      // Complete ring: empty first, then a full burst published by the peer.
      pos = own_idx;
      w = own_wrap;
      op = any_op(FUNC_PEER); op.peer_idx = pos[7:0]; op.peer_wrap = w; queue_op(op);
      op = any_op(FUNC_POP); op.count = 9'd1; queue_op(op);
      op = any_op(FUNC_QUERY); queue_op(op);
      op = any_op(FUNC_DEPOSIT); op.slot = pos[7:0]; op.value = '1; queue_op(op);
      op = any_op(FUNC_DEPOSIT); op.slot = pos[7:0] + 8'd1; queue_op(op);
      pos += BURST_MAX;
      if (pos >= SLOTS) begin
         pos -= SLOTS;
         w = ~w;
      end
      op = any_op(FUNC_PEER); op.peer_idx = pos[7:0]; op.peer_wrap = w; queue_op(op);
      op = any_op(FUNC_POP); op.count = 9'd65; queue_op(op);
      op = any_op(FUNC_POP); op.count = 9'd0; queue_op(op);
      op = any_op(FUNC_POP); op.count = 9'd64; queue_op(op);
      op = any_op(FUNC_QUERY); queue_op(op);
      op = any_op(FUNC_PUSH); op.value = 64'h8000_0000_0000_0000; queue_op(op);
      op = any_op(FUNC_ADVANCE); op.count = 9'd3; queue_op(op);

      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         write_csr(CSR_RING_KIND,
                   CSR_DATA_BITS'((ph == PHASES - 1) ? $urandom_range(0, 1) : !ph[0]));
         write_csr(CSR_RING_SIZE, phase_size[ph]);
         idle_on = (ph % 3 != 2);
         if (ph == 3) hold_arm = 1'b1;
         start = queued;
         while (queued - start < PHASE_ITEMS) begin
            wait_idle();
            span = live_size();
            if (cfg_kind) begin
               // Hardware fills slots from the software pointer, publishes its
               // pointer, and software drains the lot in bursts.
               k = $urandom_range(1, (span < 24) ? span : 24);
               if ($urandom_range(0, 9) == 0) k = (span < BURST_MAX) ? span : BURST_MAX;
               pos = own_idx;
               w = own_wrap;
               repeat (k) begin
                  op = any_op(FUNC_DEPOSIT);
                  op.slot = pos[7:0];
                  queue_op(op);
                  if (pos + 1 >= span) begin
                     pos = 0;
                     w = ~w;
                  end else begin
                     pos++;
                  end
               end
               op = any_op(FUNC_PEER); op.peer_idx = pos[7:0]; op.peer_wrap = w; queue_op(op);
               left = k;
               while (left > 0) begin
                  n = $urandom_range(1, (left < BURST_MAX) ? left : BURST_MAX);
                  op = any_op(FUNC_POP); op.count = COUNT_BITS'(n); queue_op(op);
                  left -= n;
                  if ($urandom_range(0, 3) == 0) begin
                     op = any_op(FUNC_QUERY);
                     queue_op(op);
                  end
               end
            end else begin
               // Hardware has consumed up to some distance behind software,
               // then software fills slots and moves its pointer on.
               d = $urandom_range(0, span - 1);
               pos = int'(own_idx) - d;
               w = own_wrap;
               if (pos < 0) begin
                  pos += span;
                  w = ~w;
               end
               op = any_op(FUNC_PEER); op.peer_idx = pos[7:0]; op.peer_wrap = w; queue_op(op);
               repeat ($urandom_range(1, 8)) begin
                  op = any_op(FUNC_PUSH);
                  if (op.value == '0) op.value = 64'd1;
                  queue_op(op);
               end
               if ($urandom_range(0, 1)) begin
                  op = any_op(FUNC_ADVANCE);
                  op.count = COUNT_BITS'($urandom_range(0, span));
                  queue_op(op);
               end
               op = any_op(FUNC_QUERY);
               queue_op(op);
            end
            repeat ($urandom_range(0, 2)) begin
               op = any_op(3'($urandom_range(0, 7)));
               if ($urandom_range(0, 1)) op.count = COUNT_BITS'($urandom_range(0, 70));
               if ($urandom_range(0, 7) == 0) op.value = '0;
               queue_op(op);
            end
         end
      end

      wait_idle();
      spins = 0;
      while (owed_words.size() != 0 && spins < 20000) begin
         @(negedge clock);
         spins++;
      end
      if (owed_words.size() != 0) begin
         $error("%0d result words never arrived", owed_words.size());
         mismatches++;
      end
      repeat (40) @(negedge clock);
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #8000000;
      $error("run did not finish in time");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
